FILE: src/akas_pkg.sv
// Shared constants and types for the acknowledgement and keep-alive supervisor.
// Holds operation and status codes, register indexes, reset values and the
// command and status structs passed between controller and datapath.
`default_nettype none

package akas_pkg;

   // Table depth default
   localparam int TABLE_SLOTS_DEFAULT = 16;

   // Field widths
   localparam int OP_W     = 3;
   localparam int SEQ_W    = 64;
   localparam int TIME_W   = 64;
   localparam int LIMIT_W  = 32;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;
   localparam int CSR_IDX_W = 1;

   // Operation codes
   localparam logic [OP_W-1:0] OP_START = 3'd0;
   localparam logic [OP_W-1:0] OP_TICK  = 3'd1;
   localparam logic [OP_W-1:0] OP_SENT  = 3'd2;
   localparam logic [OP_W-1:0] OP_ACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_KA    = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN_ACK = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL        = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ACK_TIMEOUT = 3'd3;
   localparam logic [STATUS_W-1:0] ST_KA_TIMEOUT  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_DOWN        = 3'd5;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ACK_WAIT           = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEEPALIVE_INTERVAL = 1'd1;

   // Register reset values
   localparam logic [LIMIT_W-1:0] ACK_WAIT_RESET           = 32'd100000000;
   localparam logic [LIMIT_W-1:0] KEEPALIVE_INTERVAL_RESET = 32'd50000000;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic scan_start;
      logic finish;
   } akas_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic link_down;
      logic scan_done;
   } akas_stat_type;

endpackage

`default_nettype wire

FILE: src/akas_ctrl.sv
// Controller for the supervisor: accepts a request, runs the table walk when
// the operation needs one and orders the final update. Depends on akas_pkg.
`default_nettype none

module akas_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [akas_pkg::OP_W-1:0]   req_operation,
   input  wire akas_pkg::akas_stat_type     stat,
   output akas_pkg::akas_cmd_type           cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;
   logic       needs_scan;

   // Hold off requests during reset and while one is in progress
   assign busy   = reset || (state_ff != S_IDLE);
   assign accept = start && !busy;

   // Decide whether the request walks the table
   always_comb begin
      needs_scan = 1'b0;
      case (req_operation) inside
         akas_pkg::OP_TICK, akas_pkg::OP_SENT, akas_pkg::OP_ACK: begin
            needs_scan = !stat.link_down;
         end
         default: begin
            needs_scan = 1'b0;
         end
      endcase
   end

   // Next state and commands
   always_comb begin
      state_in       = state_ff;
      cmd.capture    = 1'b0;
      cmd.scan_start = 1'b0;
      cmd.finish     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture    = 1'b1;
               cmd.scan_start = needs_scan;
               state_in       = needs_scan ? S_SCAN : S_FINISH;
            end
         end
         S_SCAN: begin
            if (stat.scan_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/akas_datapath.sv
// Datapath for the supervisor: entry table memory, valid bits, keep-alive
// times, configuration registers, table walk and result registers.
// Depends on akas_pkg.
`default_nettype none

module akas_datapath #(
   parameter int TABLE_SLOTS = akas_pkg::TABLE_SLOTS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire akas_pkg::akas_cmd_type           cmd,
   output akas_pkg::akas_stat_type               stat,
   input  wire logic [akas_pkg::OP_W-1:0]        req_operation,
   input  wire logic [akas_pkg::SEQ_W-1:0]       req_seq_number,
   input  wire logic [akas_pkg::TIME_W-1:0]      req_now_time,
   input  wire logic                             csr_write_enable,
   input  wire logic [akas_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [akas_pkg::LIMIT_W-1:0]     csr_write_data,
   output logic                                  rsp_strobe,
   output logic [akas_pkg::STATUS_W-1:0]         rsp_status,
   output logic                                  rsp_send_keepalive,
   output logic [akas_pkg::COUNT_W-1:0]          rsp_pending_count
);

   localparam int IDX_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int FULL_W = $clog2(TABLE_SLOTS + 1);
   localparam int CNT_W  = (FULL_W > akas_pkg::COUNT_W) ? FULL_W : akas_pkg::COUNT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

   localparam int TW = akas_pkg::TIME_W;
   localparam int LW = akas_pkg::LIMIT_W;

   // Age test without wrap: later than the record and the gap beyond the limit
   function automatic logic older_than(input logic [TW-1:0] now_t,
                                       input logic [TW-1:0] then_t,
                                       input logic [LW-1:0] limit);
      logic [TW:0] diff;
      diff = {1'b0, now_t} - {1'b0, then_t};
      return !diff[TW] &&
             ((diff[TW-1:LW] != '0) || (diff[LW-1:0] > limit));
   endfunction

   // Configuration registers
   logic [LW-1:0] ack_wait_ff;
   logic [LW-1:0] ka_interval_ff;

   // Captured request
   logic [akas_pkg::OP_W-1:0]  op_ff;
   logic [akas_pkg::SEQ_W-1:0] seq_ff;
   logic [TW-1:0]              now_ff;

   // Link state
   logic [TABLE_SLOTS-1:0] valid_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [TW-1:0]          ka_recv_ff;
   logic [TW-1:0]          ka_sent_ff;
   logic                   link_down_ff;

   // Entry memory
   logic [akas_pkg::SEQ_W-1:0] mem_seq  [TABLE_SLOTS];
   logic [TW-1:0]              mem_time [TABLE_SLOTS];
   logic [akas_pkg::SEQ_W-1:0] rd_seq_ff;
   logic [TW-1:0]              rd_time_ff;
   logic                       mem_we;

   // Walk
   logic             scan_run_ff;
   logic [IDX_W-1:0] scan_addr_ff;
   logic             s1_valid_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   logic             s1_entry_valid_ff;
   logic             qualify;
   logic             hit_ff;
   logic [IDX_W-1:0] hit_idx_ff;

   // Response registers
   logic                          rsp_strobe_ff;
   logic [akas_pkg::STATUS_W-1:0] rsp_status_ff;
   logic                          rsp_ka_ff;
   logic                          ka_recv_late;
   logic                          ka_send_due;

   assign stat.link_down = link_down_ff;
   assign stat.scan_done = s1_valid_ff && (s1_idx_ff == LAST_IDX);

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_send_keepalive = rsp_ka_ff;
   assign rsp_pending_count  = count_ff[akas_pkg::COUNT_W-1:0];

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ack_wait_ff    <= akas_pkg::ACK_WAIT_RESET;
         ka_interval_ff <= akas_pkg::KEEPALIVE_INTERVAL_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            akas_pkg::REG_ACK_WAIT:           ack_wait_ff    <= csr_write_data;
            akas_pkg::REG_KEEPALIVE_INTERVAL: ka_interval_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_operation;
         seq_ff <= req_seq_number;
         now_ff <= req_now_time;
      end
   end

   // Store a new entry and read the walked one
   assign mem_we = cmd.finish && !link_down_ff && (op_ff == akas_pkg::OP_SENT) && hit_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_seq[hit_idx_ff]  <= seq_ff;
         mem_time[hit_idx_ff] <= now_ff;
      end
      rd_seq_ff  <= mem_seq[scan_addr_ff];
      rd_time_ff <= mem_time[scan_addr_ff];
   end

   // Advance the walk address
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_run_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (cmd.scan_start) begin
            scan_run_ff <= 1'b1;
         end else if (scan_run_ff && (scan_addr_ff == LAST_IDX)) begin
            scan_run_ff <= 1'b0;
         end
         s1_valid_ff <= scan_run_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         scan_addr_ff <= '0;
      end else if (scan_run_ff) begin
         scan_addr_ff <= scan_addr_ff + IDX_W'(1);
      end
      s1_idx_ff         <= scan_addr_ff;
      s1_entry_valid_ff <= valid_ff[scan_addr_ff];
   end

   // Test the walked entry against the request
   always_comb begin
      qualify = 1'b0;
      case (op_ff)
         akas_pkg::OP_TICK: begin
            qualify = s1_entry_valid_ff && older_than(now_ff, rd_time_ff, ack_wait_ff);
         end
         akas_pkg::OP_SENT: begin
            qualify = !s1_entry_valid_ff;
         end
         akas_pkg::OP_ACK: begin
            qualify = s1_entry_valid_ff && (rd_seq_ff == seq_ff);
         end
         default: begin
            qualify = 1'b0;
         end
      endcase
   end

   // Keep the lowest qualifying slot
   always_ff @(posedge clock) begin
      if (reset || cmd.scan_start) begin
         hit_ff <= 1'b0;
      end else if (s1_valid_ff && qualify && !hit_ff) begin
         hit_ff <= 1'b1;
      end
      if (s1_valid_ff && qualify && !hit_ff) begin
         hit_idx_ff <= s1_idx_ff;
      end
   end

   assign ka_recv_late = older_than(now_ff, ka_recv_ff, ack_wait_ff);
   assign ka_send_due  = older_than(now_ff, ka_sent_ff, ka_interval_ff);

   // Apply the request and register the response
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         count_ff      <= '0;
         ka_recv_ff    <= '0;
         ka_sent_ff    <= '0;
         link_down_ff  <= 1'b1;
         rsp_strobe_ff <= 1'b0;
         rsp_status_ff <= akas_pkg::ST_OK;
         rsp_ka_ff     <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.finish;
         if (cmd.finish) begin
            rsp_status_ff <= akas_pkg::ST_OK;
            rsp_ka_ff     <= 1'b0;
            if (op_ff == akas_pkg::OP_START) begin
               valid_ff     <= '0;
               count_ff     <= '0;
               ka_recv_ff   <= now_ff;
               ka_sent_ff   <= now_ff;
               link_down_ff <= 1'b0;
            end else if (link_down_ff) begin
               rsp_status_ff <= akas_pkg::ST_DOWN;
            end else begin
               case (op_ff)
                  akas_pkg::OP_TICK: begin
                     if (hit_ff) begin
                        rsp_status_ff <= akas_pkg::ST_ACK_TIMEOUT;
                        link_down_ff  <= 1'b1;
                     end else if (ka_recv_late) begin
                        rsp_status_ff <= akas_pkg::ST_KA_TIMEOUT;
                        link_down_ff  <= 1'b1;
                     end else if (ka_send_due) begin
                        rsp_ka_ff  <= 1'b1;
                        ka_sent_ff <= now_ff;
                     end
                  end
                  akas_pkg::OP_SENT: begin
                     if (hit_ff) begin
                        valid_ff[hit_idx_ff] <= 1'b1;
                        count_ff             <= count_ff + CNT_W'(1);
                     end else begin
                        rsp_status_ff <= akas_pkg::ST_FULL;
                        link_down_ff  <= 1'b1;
                     end
                  end
                  akas_pkg::OP_ACK: begin
                     if (hit_ff) begin
                        valid_ff[hit_idx_ff] <= 1'b0;
                        count_ff             <= count_ff - CNT_W'(1);
                     end else begin
                        rsp_status_ff <= akas_pkg::ST_UNKNOWN_ACK;
                        link_down_ff  <= 1'b1;
                     end
                  end
                  akas_pkg::OP_KA: begin
                     ka_recv_ff <= now_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end
      end
   end

endmodule

`default_nettype wire

FILE: src/ack_and_keepalive_supervisor_top.sv
// Top level of the acknowledgement and keep-alive supervisor.
// Joins akas_ctrl and akas_datapath; depends on akas_pkg.
//
// Usage:
//   Request: drive req_operation, req_seq_number and req_now_time and raise
//   start; the request is taken at the clock edge where start is high and
//   busy is low. busy stays high until the request is finished.
//   Response: rsp_strobe is high for one cycle with rsp_status,
//   rsp_send_keepalive and rsp_pending_count. The receiver cannot stall it
//   and must take it in that cycle.
//   Timing: tick, message sent and ack requests on an up link walk the entry
//   table one slot per cycle through the single memory read port before the
//   response cycle; a new request may be taken in that response cycle.
//   Start, keep-alive, unused codes and any request on a down link skip the
//   walk.
//   Configuration: csr_write_enable writes csr_write_data to register
//   csr_index (0 ack wait, 1 keep-alive interval) at once; write only while
//   idle.
//   Reset: synchronous; the link comes up down, the table empty, the
//   registers at their reset values. No clearing pass is needed.
`default_nettype none

module ack_and_keepalive_supervisor_top #(
   parameter int TABLE_SLOTS = akas_pkg::TABLE_SLOTS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [akas_pkg::OP_W-1:0]        req_operation,
   input  wire logic [akas_pkg::SEQ_W-1:0]       req_seq_number,
   input  wire logic [akas_pkg::TIME_W-1:0]      req_now_time,
   output logic                                  rsp_strobe,
   output logic [akas_pkg::STATUS_W-1:0]         rsp_status,
   output logic                                  rsp_send_keepalive,
   output logic [akas_pkg::COUNT_W-1:0]          rsp_pending_count,
   input  wire logic                             csr_write_enable,
   input  wire logic [akas_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [akas_pkg::LIMIT_W-1:0]     csr_write_data
);

   akas_pkg::akas_cmd_type  cmd;
   akas_pkg::akas_stat_type stat;

   // Sequence each request
   akas_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .stat          (stat),
      .cmd           (cmd)
   );

   // Hold the table and link state
   akas_datapath #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_operation      (req_operation),
      .req_seq_number     (req_seq_number),
      .req_now_time       (req_now_time),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_send_keepalive (rsp_send_keepalive),
      .rsp_pending_count  (rsp_pending_count)
   );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the acknowledgement and keep-alive supervisor.
// Drives timestamped link events, predicts every response in step with the
// block and compares each one; depends on akas_pkg and the top level only.
`timescale 1ns / 100ps

module testbench;
   import akas_pkg::*;

   localparam int SLOTS = TABLE_SLOTS_DEFAULT;
   localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
   localparam int PHASE_REQUESTS = 200;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [SEQ_W-1:0]  seq;
      logic [TIME_W-1:0] at;
   } request_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                send_ka;
      logic [COUNT_W-1:0]  pending;
   } reply_type;

   // Block ports, every input known from time zero
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [OP_W-1:0]      req_operation = '0;
   logic [SEQ_W-1:0]     req_seq_number = '0;
   logic [TIME_W-1:0]    req_now_time = '0;
   logic                 rsp_strobe;
   logic [STATUS_W-1:0]  rsp_status;
   logic                 rsp_send_keepalive;
   logic [COUNT_W-1:0]   rsp_pending_count;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = REG_ACK_WAIT;
   logic [LIMIT_W-1:0]   csr_write_data = '0;

   // Stimulus and scoreboard state
   request_type pending_requests[$];
   reply_type   expected_replies[$];
   logic        taken = 1'b0;
   logic        calm = 1'b0;
   int unsigned gap_left = 0;
   int unsigned queued_total = 0;
   int unsigned replies_checked = 0;
   int unsigned mismatches = 0;
   int unsigned ka_asks = 0;
   int unsigned status_tally [0:7];

   // Predicted link state
   logic               slot_used [SLOTS];
   logic [SEQ_W-1:0]   slot_seq  [SLOTS];
   logic [TIME_W-1:0]  slot_time [SLOTS];
   logic [TIME_W-1:0]  ka_heard_at;
   logic [TIME_W-1:0]  ka_sent_at;
   logic               link_is_down;
   logic [LIMIT_W-1:0] wait_limit;
   logic [LIMIT_W-1:0] ka_period;

   ack_and_keepalive_supervisor_top dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_seq_number     (req_seq_number),
      .req_now_time       (req_now_time),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_send_keepalive (rsp_send_keepalive),
      .rsp_pending_count  (rsp_pending_count),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #6 clock = ~clock;

   // Age test: only a strictly later time can exceed the limit, no wrap
   function automatic logic is_stale(input logic [TIME_W-1:0] now_t,
                                     input logic [TIME_W-1:0] then_t,
                                     input logic [LIMIT_W-1:0] limit);
      return (now_t > then_t) && ((now_t - then_t) > {32'h0, limit});
   endfunction

   // Advance the predicted link state by one request and form its reply
   function automatic reply_type supervise_event(input request_type ev);
      reply_type r;
      logic      done;
      r.status  = ST_OK;
      r.send_ka = 1'b0;
      r.pending = '0;
      done      = 1'b0;
      if (ev.op == OP_START) begin
         for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
         ka_heard_at  = ev.at;
         ka_sent_at   = ev.at;
         link_is_down = 1'b0;
      end else if (link_is_down) begin
         r.status = ST_DOWN;
      end else begin
         case (ev.op)
            OP_TICK: begin
               for (int i = 0; i < SLOTS; i++)
                  if (slot_used[i] && is_stale(ev.at, slot_time[i], wait_limit))
                     r.status = ST_ACK_TIMEOUT;
               if (r.status == ST_OK && is_stale(ev.at, ka_heard_at, wait_limit))
                  r.status = ST_KA_TIMEOUT;
               if (r.status != ST_OK) begin
                  link_is_down = 1'b1;
               end else if (is_stale(ev.at, ka_sent_at, ka_period)) begin
                  r.send_ka  = 1'b1;
                  ka_sent_at = ev.at;
               end
            end
            OP_SENT: begin
               for (int i = 0; i < SLOTS && !done; i++)
                  if (!slot_used[i]) begin
                     slot_used[i] = 1'b1;
                     slot_seq[i]  = ev.seq;
                     slot_time[i] = ev.at;
                     done         = 1'b1;
                  end
               if (!done) begin
                  r.status     = ST_FULL;
                  link_is_down = 1'b1;
               end
            end
            OP_ACK: begin
               for (int i = 0; i < SLOTS && !done; i++)
                  if (slot_used[i] && slot_seq[i] == ev.seq) begin
                     slot_used[i] = 1'b0;
                     done         = 1'b1;
                  end
               if (!done) begin
                  r.status     = ST_UNKNOWN_ACK;
                  link_is_down = 1'b1;
               end
            end
            OP_KA: ka_heard_at = ev.at;
            default: ;
         endcase
      end
      for (int i = 0; i < SLOTS; i++) r.pending = r.pending + COUNT_W'(slot_used[i]);
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      mismatches++;
      $display("%0t: mismatch on %s after %0d replies: got %0h, expected %0h",
               $realtime, what, replies_checked, got, want);
   endtask

   // Monitor: track register writes, predict on acceptance, check replies
   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         taken <= 1'b0;
         for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
         ka_heard_at  = '0;
         ka_sent_at   = '0;
         link_is_down = 1'b1;
         wait_limit   = ACK_WAIT_RESET;
         ka_period    = KEEPALIVE_INTERVAL_RESET;
      end else begin
         taken <= start && !busy;
         if (csr_write_enable) begin
            if (csr_index == REG_ACK_WAIT) wait_limit = csr_write_data;
            else ka_period = csr_write_data;
         end
         if (rsp_strobe) begin
            if (expected_replies.size() == 0) begin
               flag_mismatch("reply with no request outstanding", 64'(rsp_status), 64'd0);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_status !== want.status)
                  flag_mismatch("status", 64'(rsp_status), 64'(want.status));
               if (rsp_send_keepalive !== want.send_ka)
                  flag_mismatch("send_keepalive", 64'(rsp_send_keepalive),
                                64'(want.send_ka));
               if (rsp_pending_count !== want.pending)
                  flag_mismatch("pending_count", 64'(rsp_pending_count),
                                64'(want.pending));
               replies_checked++;
               status_tally[want.status]++;
               if (want.send_ka) ka_asks++;
            end
         end
         if (start && !busy)
            expected_replies.push_back(supervise_event('{req_operation, req_seq_number,
                                                         req_now_time}));
      end
   end

   // Driver: hold a request until taken, then idle in bursts or present the next
   always @(negedge clock) begin
      request_type nxt;
      if (!reset) begin
         if (start && !taken) begin
            // hold the request in place
         end else if (gap_left != 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_requests.size() != 0) begin
            nxt = pending_requests.pop_front();
            req_operation  <= nxt.op;
            req_seq_number <= nxt.seq;
            req_now_time   <= nxt.at;
            start          <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 15);
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic add_event(input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] seq,
                            input logic [TIME_W-1:0] at);
      pending_requests.push_back('{op, seq, at});
      queued_total++;
   endtask

   // Wait until every request is answered, then let the block drain
   task automatic settle();
      do @(negedge clock);
      while (pending_requests.size() != 0 || start || expected_replies.size() != 0);
      repeat (24) @(negedge clock);
   endtask

   task automatic write_limits(input logic [LIMIT_W-1:0] wait_v,
                               input logic [LIMIT_W-1:0] period_v);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= REG_ACK_WAIT;
      csr_write_data   <= wait_v;
      @(negedge clock);
      csr_index        <= REG_KEEPALIVE_INTERVAL;
      csr_write_data   <= period_v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // One link session: start, then mostly sensible traffic with random content;
   // occasional floods, stray acks, time jumps and spare codes break it
   task automatic queue_session(input logic [LIMIT_W-1:0] wait_v);
      logic [SEQ_W-1:0]  live[$];
      logic [TIME_W-1:0] stamp;
      logic [TIME_W-1:0] span;
      logic [SEQ_W-1:0]  seq;
      int unsigned       n, pick, idx;
      logic              flood;
      pick = $urandom_range(0, 9);
      if (pick < 3) stamp = {32'h0, $urandom};
      else if (pick == 3)
         stamp = 64'hFFFF_FFFF_FFFF_FFFF - TIME_W'($urandom_range(0, 1000000));
      else stamp = {$urandom, $urandom};
      add_event(OP_START, {$urandom, $urandom}, stamp);
      flood = ($urandom_range(0, 11) == 0);
      span  = {32'h0, wait_v >> 2} + 64'd3;
      n     = flood ? SLOTS + 2 : $urandom_range(4, 40);
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) stamp = stamp - TIME_W'($urandom_range(0, 1000));
         else if (pick < 7)
            stamp = stamp + {32'h0, wait_v} + TIME_W'($urandom_range(1, 64));
         else stamp = stamp + ({$urandom, $urandom} % span);
         pick = $urandom_range(0, 99);
         if (flood || pick < 30 || (pick < 60 && live.size() == 0)) begin
            if (live.size() != 0 && $urandom_range(0, 9) == 0)
               seq = live[$urandom_range(0, live.size() - 1)];
            else
               seq = {$urandom, $urandom};
            if (live.size() < SLOTS) live.push_back(seq);
            add_event(OP_SENT, seq, stamp);
         end else if (pick < 60) begin
            if ($urandom_range(0, 19) == 0) begin
               seq = {$urandom, $urandom};
            end else begin
               idx = $urandom_range(0, live.size() - 1);
               seq = live[idx];
               live.delete(idx);
            end
            add_event(OP_ACK, seq, stamp);
         end else if (pick < 75) begin
            add_event(OP_KA, {$urandom, $urandom}, stamp);
         end else if (pick < 97) begin
            add_event(OP_TICK, {$urandom, $urandom}, stamp);
         end else if (pick < 99) begin
            add_event(OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                      {$urandom, $urandom}, stamp);
         end else begin
            add_event(OP_START, {$urandom, $urandom}, stamp);
            live.delete();
         end
      end
   endtask

   initial begin
      logic [LIMIT_W-1:0] wait_v, period_v;
      int unsigned        target;
      foreach (status_tally[i]) status_tally[i] = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Directed: link down after reset, keep-alive request, both timeouts,
      // duplicates, unknown ack, spare codes and a start at the top of time
      add_event(OP_TICK, 64'd0, 64'd0);
      add_event(OP_SPARE_LAST, 64'd0, 64'd0);
      add_event(OP_START, 64'd0, 64'd0);
      add_event(OP_SPARE_FIRST, 64'd0, 64'd1);
      add_event(OP_SENT, 64'd0, 64'd10);
      add_event(OP_SENT, 64'hFFFF_FFFF_FFFF_FFFF, 64'd20);
      add_event(OP_SENT, 64'hFFFF_FFFF_FFFF_FFFF, 64'd30);
      add_event(OP_ACK, 64'hFFFF_FFFF_FFFF_FFFF, 64'd35);
      add_event(OP_KA, 64'd0, 64'd40);
      add_event(OP_TICK, 64'd0, 64'd50000001);
      add_event(OP_TICK, 64'd0, 64'd50000001);
      add_event(OP_TICK, 64'd0, 64'd100000011);
      add_event(OP_SENT, 64'd7, 64'd100000012);
      add_event(OP_START, 64'd0, 64'hFFFF_FFFF_FFFF_FFFA);
      add_event(OP_TICK, 64'd0, 64'd3);
      add_event(OP_ACK, 64'd5, 64'd4);
      add_event(OP_START, 64'd0, 64'd0);
      add_event(OP_TICK, 64'd0, 64'd100000001);
      settle();

      // Random: one register setting per phase, the last phase without idling
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin wait_v = 32'd1000;       period_v = 32'd300;        end
            1: begin wait_v = 32'd0;          period_v = 32'd0;          end
            2: begin wait_v = 32'hFFFF_FFFF;  period_v = 32'hFFFF_FFFF;  end
            3: begin wait_v = $urandom;       period_v = $urandom;       end
            4: begin
               wait_v   = $urandom_range(50, 5000);
               period_v = $urandom_range(1, wait_v);
            end
            default: begin wait_v = 32'd5000; period_v = 32'd2000; end
         endcase
         if (phase == 5) calm = 1'b1;
         write_limits(wait_v, period_v);
         target = queued_total + PHASE_REQUESTS;
         while (queued_total < target) queue_session(wait_v);
         settle();
      end

      if (expected_replies.size() != 0)
         flag_mismatch("replies never delivered", 64'd0, 64'(expected_replies.size()));
      $display("Checked %0d replies across directed cases and six register settings:",
               replies_checked);
      $display("  ok %0d, unknown ack %0d, full %0d, ack timeout %0d,",
               status_tally[ST_OK], status_tally[ST_UNKNOWN_ACK], status_tally[ST_FULL],
               status_tally[ST_ACK_TIMEOUT]);
      $display("  keep-alive timeout %0d, down %0d, keep-alive asks %0d",
               status_tally[ST_KA_TIMEOUT], status_tally[ST_DOWN], ka_asks);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #5000000;
      $display("Timed out with %0d replies still awaited", expected_replies.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: ack_and_keepalive_supervisor_top.f
src/akas_pkg.sv
src/akas_ctrl.sv
src/akas_datapath.sv
src/ack_and_keepalive_supervisor_top.sv
tb/testbench.sv
